// ===== sv/psd_pkg.sv =====
// Package for the pending service dispatcher: item kinds, widths and record types.
// No dependencies; used by pending_service_dispatcher_unit.
package psd_pkg;

    localparam int SERVICES_DEF = 16;
    localparam int ID_W         = 5;
    localparam int OUT_ID_W     = 4;
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 64;

    // Input item kinds.
    localparam logic [2:0] K_SIGNAL   = 3'd0;
    localparam logic [2:0] K_DISPATCH = 3'd1;
    localparam logic [2:0] K_COMPLETE = 3'd2;
    localparam logic [2:0] K_REGISTER = 3'd3;
    localparam logic [2:0] K_DISABLE  = 3'd4;
    localparam logic [2:0] K_READ     = 3'd5;

    // Per-service statistics record held in the counter memory.
    typedef struct packed {
        logic [CNT_W-1:0] sig;
        logic [CNT_W-1:0] coal;
        logic [CNT_W-1:0] disp;
        logic [SUM_W-1:0] tsum;
        logic [CNT_W-1:0] tmax;
        logic [CNT_W-1:0] exh;
    } t_stats;

    // Per-service descriptor held in the descriptor memory.
    typedef struct packed {
        logic             active;
        logic             handler;
        logic [CNT_W-1:0] budget;
    } t_desc;

endpackage

// ===== sv/pending_service_dispatcher_unit.sv =====
// Top level of the pending service dispatcher.
// Depends on psd_pkg for kinds and record types.
//
// One transaction at a time. Signal, completion, register and disable occupy the
// block while the memories are read in the accepting cycle and the record is
// modified and written back in the next, after which the block is ready again. A
// read is handled the same way and holds the block for as long as the output register
// is still full. A dispatch scans one service per cycle after it is accepted, except
// that the scan stalls while a new hit finds the output register full and an earlier
// hit is still held. It issues one result per qualifying service through the output
// register. State lives in two memories (descriptors and statistics), each read
// through a registered read port. The valid bits of both are flip-flops cleared by
// reset, so a never-written entry reads as zero.
module pending_service_dispatcher_unit #(
    parameter int SERVICES = psd_pkg::SERVICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0]                i_kind,
    input  logic [psd_pkg::ID_W-1:0]  i_service_id,
    input  logic [31:0]               i_budget,
    input  logic                      i_handler_present,
    input  logic                      i_more_work,
    input  logic [31:0]               i_duration_us,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [3:0]                o_dispatch_id,
    output logic [31:0]               o_dispatch_budget,
    output logic                      o_last,
    output logic [31:0]               o_signals_total,
    output logic [31:0]               o_coalesced_total,
    output logic [31:0]               o_dispatches_total,
    output logic [63:0]               o_time_total_us,
    output logic [31:0]               o_time_max_us,
    output logic [31:0]               o_exhaustions_total
);
    import psd_pkg::*;

    localparam int AW = (SERVICES > 1) ? $clog2(SERVICES) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RMW   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [SERVICES-1:0] r_pend;
    logic [SERVICES-1:0] r_claim;
    logic [SERVICES-1:0] r_dvalid, r_svalid;
    logic [2:0]          r_kind;
    logic [AW-1:0]       r_id;
    logic [31:0]         r_budget, r_dur;
    logic                r_hand, r_more;
    logic [AW:0]         r_scan;

    // Memories.
    t_desc  mem_desc [SERVICES];
    t_stats mem_stat [SERVICES];
    t_desc  r_drd;
    t_stats r_srd;
    logic   r_drd_ok, r_srd_ok;

    // Pending result held for the emitter while the scan looks further.
    logic        r_hold_v;
    logic [3:0]  r_hold_id;
    logic [31:0] r_hold_bud;

    // Output register.
    logic        r_ov;
    logic [3:0]  r_oid;
    logic [31:0] r_obud;
    logic        r_olast;
    t_stats      r_ost;

    logic   in_ok;
    logic   id_ok;
    logic [AW-1:0] rd_addr;
    t_desc  desc_q;
    t_stats stat_q;
    logic   out_free;
    logic   scan_hit;
    logic   scan_stall;

    assign o_ready = (r_state == S_IDLE);
    assign in_ok   = i_valid && o_ready;
    assign id_ok   = ({27'd0, i_service_id} < 32'(SERVICES));
    assign out_free = !r_ov || i_ready;

    // Read address: the incoming id, or the scan pointer during a dispatch.
    // A stalled scan reads the entry under test again so the data stays aligned.
    always_comb begin
        if (r_state == S_SCAN) begin
            if (scan_stall) begin
                rd_addr = r_scan[AW-1:0] - AW'(1);
            end else begin
                rd_addr = r_scan[AW-1:0];
            end
        end else begin
            rd_addr = i_service_id[AW-1:0];
        end
    end

    // Synchronous reads: the address is applied and the data is registered.
    always_ff @(posedge i_clk) begin
        r_drd    <= mem_desc[rd_addr];
        r_srd    <= mem_stat[rd_addr];
        r_drd_ok <= r_dvalid[rd_addr];
        r_srd_ok <= r_svalid[rd_addr];
    end

    assign desc_q = r_drd_ok ? r_drd : '0;
    assign stat_q = r_srd_ok ? r_srd : '0;

    // Modified records for the write-back of a single-service transaction.
    t_desc  desc_n;
    t_stats stat_n;
    logic   sig_do;
    logic   was_pend;

    always_comb begin
        desc_n   = desc_q;
        stat_n   = stat_q;
        sig_do   = 1'b0;
        was_pend = r_pend[r_id];
        case (r_kind)
            K_SIGNAL: begin
                sig_do = desc_q.active;
            end
            K_COMPLETE: begin
                stat_n.disp = stat_q.disp + 32'd1;
                stat_n.tsum = stat_q.tsum + {32'd0, r_dur};
                if (r_dur > stat_q.tmax) begin
                    stat_n.tmax = r_dur;
                end
                if (r_more) begin
                    stat_n.exh = stat_q.exh + 32'd1;
                    sig_do = desc_q.active;
                end
            end
            K_REGISTER: begin
                desc_n.active  = 1'b1;
                desc_n.handler = r_hand;
                desc_n.budget  = r_budget;
            end
            K_DISABLE: begin
                desc_n.active = 1'b0;
            end
            default: begin
            end
        endcase
        if (sig_do) begin
            stat_n.sig = stat_n.sig + 32'd1;
            if (was_pend) begin
                stat_n.coal = stat_n.coal + 32'd1;
            end
        end
    end

    // Memory write-back.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW) begin
            mem_desc[r_id] <= desc_n;
            mem_stat[r_id] <= stat_n;
        end
    end

    assign scan_hit = (r_state == S_SCAN) && (r_scan != '0) &&
                      r_claim[r_scan[AW-1:0] - AW'(1)] &&
                      desc_q.active && desc_q.handler;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_ok) begin
                    if (i_kind == K_DISPATCH) begin
                        n_state = S_SCAN;
                    end else if (id_ok && i_kind <= K_READ) begin
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                n_state = (r_kind == K_READ && !out_free) ? S_WAIT : S_IDLE;
            end
            S_SCAN: begin
                if (r_hold_v && scan_hit && !out_free) begin
                    n_state = S_SCAN;
                end else if (r_scan == (AW+1)'(SERVICES)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_hold_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign scan_stall = (r_state == S_SCAN) && r_hold_v && scan_hit && !out_free;

    // Statistics of a read, kept while the result waits for the output register.
    t_stats r_wait_st;
    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW) begin
            r_wait_st <= stat_q;
        end
    end

    // Control and data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= '0;
            r_dvalid <= '0;
            r_svalid <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
            r_scan   <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (in_ok) begin
                r_kind   <= i_kind;
                r_id     <= i_service_id[AW-1:0];
                r_budget <= i_budget;
                r_hand   <= i_handler_present;
                r_more   <= i_more_work;
                r_dur    <= i_duration_us;
                if (i_kind == K_DISPATCH) begin
                    r_claim <= r_pend;
                    r_pend  <= '0;
                    r_scan  <= '0;
                end
            end
            if (r_state == S_RMW) begin
                r_dvalid[r_id] <= 1'b1;
                r_svalid[r_id] <= 1'b1;
                if (sig_do) begin
                    r_pend[r_id] <= 1'b1;
                end
                if (r_kind == K_READ && out_free) begin
                    r_ov    <= 1'b1;
                    r_oid   <= 4'(r_id);
                    r_obud  <= '0;
                    r_olast <= 1'b1;
                    r_ost   <= stat_q;
                end
            end
            if (r_state == S_WAIT && out_free) begin
                r_ov    <= 1'b1;
                r_oid   <= 4'(r_id);
                r_obud  <= '0;
                r_olast <= 1'b1;
                r_ost   <= r_wait_st;
            end
            // Scan: the held hit goes out once a later hit proves it is not last.
            if (r_state == S_SCAN && !scan_stall) begin
                if (r_scan != (AW+1)'(SERVICES)) begin
                    r_scan <= r_scan + (AW+1)'(1);
                end
                if (scan_hit) begin
                    if (r_hold_v) begin
                        r_ov    <= 1'b1;
                        r_oid   <= r_hold_id;
                        r_obud  <= r_hold_bud;
                        r_olast <= 1'b0;
                        r_ost   <= '0;
                    end
                    r_hold_v   <= 1'b1;
                    r_hold_id  <= 4'(r_scan - (AW+1)'(1));
                    r_hold_bud <= desc_q.budget;
                end
            end
            if (r_state == S_EMIT && r_hold_v && out_free) begin
                r_ov     <= 1'b1;
                r_oid    <= r_hold_id;
                r_obud   <= r_hold_bud;
                r_olast  <= 1'b1;
                r_ost    <= '0;
                r_hold_v <= 1'b0;
            end
        end
    end

    assign o_valid             = r_ov;
    assign o_dispatch_id       = r_oid;
    assign o_dispatch_budget   = r_obud;
    assign o_last              = r_olast;
    assign o_signals_total     = r_ost.sig;
    assign o_coalesced_total   = r_ost.coal;
    assign o_dispatches_total  = r_ost.disp;
    assign o_time_total_us     = r_ost.tsum;
    assign o_time_max_us       = r_ost.tmax;
    assign o_exhaustions_total = r_ost.exh;

`ifndef NO_ASSERTIONS
    // A result is never issued while the block is ready for new input.
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> !(r_ov && !$past(r_ov) && $past(r_state) == S_IDLE))
        else $error("result issued from idle");
    // The pending mask is empty right after a dispatch is accepted.
    a_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ok && i_kind == K_DISPATCH) |=> (r_pend == '0))
        else $error("pending mask not cleared on dispatch");
    // A held result is never left behind when the block returns to idle.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held dispatch result lost");
`endif

endmodule

// ===== tb/pending_service_dispatcher_unit_tb.sv =====
// Self-checking testbench for pending_service_dispatcher_unit.
// Depends on psd_pkg for item kinds; drives a directed table and then random
// transactions, comparing every result against an internal service-table predictor.
`timescale 1ns / 1ps

module pending_service_dispatcher_unit_tb;
    import psd_pkg::*;

    localparam int NSVC      = SERVICES_DEF;
    localparam int MAX_CYCLE = 400000;
    localparam int N_RANDOM  = 180;

    // Expected result record.
    typedef struct {
        logic [3:0]  id;
        logic [31:0] budget;
        logic        last;
        logic [31:0] sigs;
        logic [31:0] coal;
        logic [31:0] disp;
        logic [63:0] tsum;
        logic [31:0] tmax;
        logic [31:0] exh;
    } t_result;

    // One input transaction, with an optional hand-typed expectation.
    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  sid;
        logic [31:0] budget;
        logic        handler;
        logic        more;
        logic [31:0] dur;
        bit          typed;
        t_result     typed_res;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [4:0]  i_service_id = '0;
    logic [31:0] i_budget = '0;
    logic        i_handler_present = 1'b0;
    logic        i_more_work = 1'b0;
    logic [31:0] i_duration_us = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_dispatch_id;
    logic [31:0] o_dispatch_budget;
    logic        o_last;
    logic [31:0] o_signals_total;
    logic [31:0] o_coalesced_total;
    logic [31:0] o_dispatches_total;
    logic [63:0] o_time_total_us;
    logic [31:0] o_time_max_us;
    logic [31:0] o_exhaustions_total;

    pending_service_dispatcher_unit uut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow copy of the service table.
    logic [15:0] pend_mask;
    logic        svc_active [NSVC];
    logic        svc_handler[NSVC];
    logic [31:0] svc_budget [NSVC];
    logic [31:0] cnt_sig    [NSVC];
    logic [31:0] cnt_coal   [NSVC];
    logic [31:0] cnt_disp   [NSVC];
    logic [63:0] cnt_tsum   [NSVC];
    logic [31:0] cnt_tmax   [NSVC];
    logic [31:0] cnt_exh    [NSVC];

    t_result expected_results[$];
    t_item   stim_table[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      cycle_count = 0;
    bit      rx_stall_mode = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void table_signal(input int id);
        if (!svc_active[id]) return;
        cnt_sig[id]++;
        if (pend_mask[id]) cnt_coal[id]++;
        pend_mask[id] = 1'b1;
    endfunction

    // Advances the shadow table by one transaction and queues its results.
    function automatic void predict_service_item(input t_item it);
        logic [15:0] claimed;
        t_result     r;
        int          n;
        int          id;
        n  = 0;
        id = it.sid;
        r  = '{default: '0};
        if (it.kind == K_DISPATCH) begin
            claimed   = pend_mask;
            pend_mask = '0;
            for (int i = 0; i < NSVC; i++) begin
                if (claimed[i] && svc_active[i] && svc_handler[i] && n < 16) begin
                    r = '{default: '0};
                    r.id = i[3:0];
                    r.budget = svc_budget[i];
                    expected_results.push_back(r);
                    n++;
                end
            end
            if (n > 0) expected_results[$].last = 1'b1;
            return;
        end
        if (it.kind > K_READ || id >= NSVC) return;
        case (it.kind)
            K_SIGNAL: table_signal(id);
            K_COMPLETE: begin
                cnt_disp[id]++;
                cnt_tsum[id] += 64'(it.dur);
                if (it.dur > cnt_tmax[id]) cnt_tmax[id] = it.dur;
                if (it.more) begin
                    cnt_exh[id]++;
                    table_signal(id);
                end
            end
            K_REGISTER: begin
                svc_handler[id] = it.handler;
                svc_budget[id]  = it.budget;
                svc_active[id]  = 1'b1;
            end
            K_DISABLE: svc_active[id] = 1'b0;
            default: begin
                r.id   = id[3:0];
                r.last = 1'b1;
                r.sigs = cnt_sig[id];
                r.coal = cnt_coal[id];
                r.disp = cnt_disp[id];
                r.tsum = cnt_tsum[id];
                r.tmax = cnt_tmax[id];
                r.exh  = cnt_exh[id];
                expected_results.push_back(r);
            end
        endcase
    endfunction

    function automatic t_item mk(input logic [2:0] k, input logic [4:0] s,
                                 input logic [31:0] b = 0, input logic h = 0,
                                 input logic m = 0, input logic [31:0] d = 0);
        t_item it;
        it = '{kind: k, sid: s, budget: b, handler: h, more: m, dur: d,
               typed: 1'b0, typed_res: '{default: '0}};
        return it;
    endfunction

    // Random transaction, weighted toward services that exist.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it = mk(3'($urandom_range(0, 5)), 5'($urandom_range(0, NSVC - 1)), $urandom(),
                1'($urandom), 1'($urandom), $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 30) it.kind = K_SIGNAL;
        else if (pick < 42) it.kind = K_DISPATCH;
        else if (pick < 55) it.kind = K_COMPLETE;
        else if (pick < 65) it.kind = K_REGISTER;
        else if (pick < 70) it.kind = K_DISABLE;
        else if (pick < 82) it.kind = K_READ;
        else if (pick < 86) it.kind = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) == 0) it.sid = 5'($urandom_range(NSVC, 31));
        if ($urandom_range(0, 3) == 0) begin
            it.dur = 32'($urandom_range(0, 3)) |
                     {$urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0};
        end
        return it;
    endfunction

    // Receiver: stall pattern alternates between free-running and a periodic mask, thinned further at random.
    always @(negedge i_clk) begin
        if (cycle_count % 97 == 0) rx_stall_mode <= ~rx_stall_mode;
        if (!rx_stall_mode) i_ready <= 1'b1;
        else i_ready <= ((cycle_count % 5) < 3) && ($urandom_range(0, 3) != 0);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result id", 64'(o_dispatch_id), '0);
            end else begin
                e = expected_results.pop_front();
                if (o_dispatch_id !== e.id) report_mismatch("id", o_dispatch_id, e.id);
                if (o_dispatch_budget !== e.budget)
                    report_mismatch("budget", o_dispatch_budget, e.budget);
                if (o_last !== e.last) report_mismatch("last", o_last, e.last);
                if (o_signals_total !== e.sigs)
                    report_mismatch("signals", o_signals_total, e.sigs);
                if (o_coalesced_total !== e.coal)
                    report_mismatch("coalesced", o_coalesced_total, e.coal);
                if (o_dispatches_total !== e.disp)
                    report_mismatch("dispatches", o_dispatches_total, e.disp);
                if (o_time_total_us !== e.tsum)
                    report_mismatch("time sum", o_time_total_us, e.tsum);
                if (o_time_max_us !== e.tmax)
                    report_mismatch("time max", o_time_max_us, e.tmax);
                if (o_exhaustions_total !== e.exh)
                    report_mismatch("exhaustions", o_exhaustions_total, e.exh);
            end
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycle_count >= MAX_CYCLE) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("** pending_service_dispatcher_unit: FAILED **");
            $finish;
        end
    end

    // Presents one transaction and waits for it to be taken.
    task automatic send_item(input t_item it);
        i_kind            <= it.kind;
        i_service_id      <= it.sid;
        i_budget          <= it.budget;
        i_handler_present <= it.handler;
        i_more_work       <= it.more;
        i_duration_us     <= it.dur;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (it.typed) begin
            predict_service_item(it);
            if (expected_results.size() > 0 && it.kind == K_READ) begin
                if (expected_results[$] != it.typed_res) begin
                    report_mismatch("typed read expectation, id", 64'(it.sid),
                                    64'(it.typed_res.id));
                end
            end
        end else begin
            predict_service_item(it);
        end
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (NSVC + 8) @(negedge i_clk);
    endtask

    initial begin
        t_item   it;
        t_result zr;
        int      burst;
        int      gap;
        int      sent;

        for (int i = 0; i < NSVC; i++) begin
            svc_active[i] = 0; svc_handler[i] = 0; svc_budget[i] = 0;
            cnt_sig[i] = 0; cnt_coal[i] = 0; cnt_disp[i] = 0;
            cnt_tsum[i] = 0; cnt_tmax[i] = 0; cnt_exh[i] = 0;
        end
        pend_mask = '0;

        // Directed table: read after reset, extremes, every kind and corner case.
        zr = '{default: '0};
        it = mk(K_READ, 0); it.typed = 1; it.typed_res = zr; it.typed_res.last = 1;
        stim_table.push_back(it);
        it = mk(K_READ, 15); it.typed = 1; it.typed_res = zr;
        it.typed_res.id = 4'd15; it.typed_res.last = 1;
        stim_table.push_back(it);
        stim_table.push_back(mk(K_SIGNAL, 3));                         // inactive: ignored
        stim_table.push_back(mk(K_DISPATCH, 0));                       // empty dispatch
        stim_table.push_back(mk(K_REGISTER, 0, 32'hFFFF_FFFF, 1));
        stim_table.push_back(mk(K_REGISTER, 15, 32'h0, 1));
        stim_table.push_back(mk(K_REGISTER, 7, 32'hA5A5_5A5A, 0));     // no handler
        stim_table.push_back(mk(K_REGISTER, 31, 32'h1234, 1));         // out of range
        stim_table.push_back(mk(K_SIGNAL, 0));
        stim_table.push_back(mk(K_SIGNAL, 0));                         // coalesced
        stim_table.push_back(mk(K_SIGNAL, 15));
        stim_table.push_back(mk(K_SIGNAL, 7));
        stim_table.push_back(mk(3'd6, 0));                             // unknown kinds
        stim_table.push_back(mk(3'd7, 15));
        stim_table.push_back(mk(K_DISPATCH, 31));
        stim_table.push_back(mk(K_COMPLETE, 0, 0, 0, 1, 32'hFFFF_FFFF));
        stim_table.push_back(mk(K_COMPLETE, 0, 0, 0, 0, 32'hFFFF_FFFF)); // sum carries
        stim_table.push_back(mk(K_COMPLETE, 15, 0, 0, 1, 0));
        stim_table.push_back(mk(K_DISABLE, 15));
        stim_table.push_back(mk(K_SIGNAL, 15));                        // disabled
        stim_table.push_back(mk(K_COMPLETE, 20, 0, 0, 1, 5));          // out of range
        stim_table.push_back(mk(K_READ, 0));
        stim_table.push_back(mk(K_READ, 15));
        stim_table.push_back(mk(K_READ, 16));
        stim_table.push_back(mk(K_DISPATCH, 0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[k]) send_item(stim_table[k]);
        drop_valid();
        wait_drained();

        // Register every service so that dispatches can run long.
        for (int i = 0; i < NSVC; i++) begin
            send_item(mk(K_REGISTER, 5'(i), $urandom(), 1'($urandom_range(0, 3) != 0)));
            send_item(mk(K_SIGNAL, 5'(i)));
        end
        send_item(mk(K_DISPATCH, 0));
        drop_valid();

        // Random bursts with gaps; a full drain midway.
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                send_item(random_item());
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                drop_valid();
                repeat (gap) @(negedge i_clk);
            end
            if (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + burst + 1) begin
                drop_valid();
                wait_drained();
            end
        end
        for (int i = 0; i < NSVC; i++) send_item(mk(K_READ, 5'(i)));
        send_item(mk(K_DISPATCH, 0));
        drop_valid();
        wait_drained();

        $display("Ran %0d directed and %0d random transactions; %0d results checked.",
                 stim_table.size(), N_RANDOM, results_seen);
        $display("Covered signal, coalescing, dispatch, completion, register, disable and reads.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("** pending_service_dispatcher_unit: PASSED **");
        end else begin
            $display("** pending_service_dispatcher_unit: FAILED **");
        end
        $finish;
    end

endmodule
